// ===== rtl/depq_pkg.sv =====
// Shared constants and types for the double-ended priority queue.
package depq_pkg;

   localparam int DefCapacity = 64;
   localparam int ValueW      = 32;
   localparam int KindW       = 2;

   typedef enum logic [KindW-1:0] {
      KIND_INSERT  = 2'd0,
      KIND_DEL_MIN = 2'd1,
      KIND_DEL_MAX = 2'd2,
      KIND_NOP     = 2'd3
   } kind_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;   // latch the accepted word
      logic exec;       // apply the operation to the cell row
      logic report;     // load the result register
   } ctrl_type;

endpackage

// ===== rtl/depq_ctrl.sv =====
// Sequencer for the queue: accept, execute, report.
module depq_ctrl
   import depq_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   output ctrl_type ctrl
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_REPORT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      ctrl.load_req = 1'b0;
      ctrl.exec     = 1'b0;
      ctrl.report   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               ctrl.load_req = 1'b1;
               state_in      = ST_EXEC;
            end
         end
         ST_EXEC: begin
            ctrl.exec = 1'b1;
            state_in  = ST_REPORT;
         end
         ST_REPORT: begin
            if (rsp_free) begin
               ctrl.report  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/depq_dpath.sv =====
// Sorted cell row, count and result register.
module depq_dpath
   import depq_pkg::*;
#(
   parameter int CAPACITY = DefCapacity,
   parameter int CNT_W    = $clog2(CAPACITY + 1),
   parameter int IDX_W    = $clog2(CAPACITY)
) (
   input  logic              clock,
   input  logic              reset,
   input  ctrl_type          ctrl,
   input  logic [KindW-1:0]  req_kind,
   input  logic [ValueW-1:0] req_value,
   output logic [ValueW-1:0] max_value,
   output logic [ValueW-1:0] min_value,
   output logic              is_empty,
   output logic [CNT_W-1:0]  entry_count,
   output logic              dropped
);

   logic [ValueW-1:0] cell_ff [CAPACITY];
   logic [ValueW-1:0] cell_in [CAPACITY];
   logic [CAPACITY-1:0] gt;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [KindW-1:0]  kind_ff;
   logic [ValueW-1:0] key_ff;
   logic              drop_ff, drop_in;
   logic [CNT_W-1:0]  last_idx;
   logic              full;

   assign full     = (count_ff == CNT_W'(CAPACITY));
   assign last_idx = count_ff - CNT_W'(1);

   // cells above the key among the held ones; a suffix since the row is sorted
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         gt[i] = (CNT_W'(i) < count_ff) && ($signed(cell_ff[i]) > $signed(key_ff));
      end
   end

   always_comb begin
      count_in = count_ff;
      drop_in  = 1'b0;
      for (int i = 0; i < CAPACITY; i++) cell_in[i] = cell_ff[i];
      case (kind_type'(kind_ff))
         KIND_INSERT: begin
            if (full) begin
               drop_in = 1'b1;
            end else begin
               count_in = count_ff + CNT_W'(1);
               for (int i = 0; i < CAPACITY; i++) begin
                  if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
                     cell_in[i] = cell_ff[(i > 0) ? i - 1 : 0];
                  end else if (gt[i] || CNT_W'(i) == count_ff) begin
                     cell_in[i] = key_ff;
                  end
               end
            end
         end
         KIND_DEL_MIN: begin
            if (count_ff != '0) begin
               count_in = count_ff - CNT_W'(1);
               for (int i = 0; i < CAPACITY - 1; i++) cell_in[i] = cell_ff[i + 1];
            end
         end
         KIND_DEL_MAX: begin
            if (count_ff != '0) count_in = count_ff - CNT_W'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (ctrl.exec) begin
         count_ff <= count_in;
      end
      if (ctrl.exec) begin
         drop_ff <= drop_in;
         for (int i = 0; i < CAPACITY; i++) cell_ff[i] <= cell_in[i];
      end
      if (ctrl.load_req) begin
         kind_ff <= req_kind;
         key_ff  <= req_value;
      end
      if (ctrl.report) begin
         entry_count <= count_ff;
         dropped     <= drop_ff;
         is_empty    <= (count_ff == '0);
         max_value   <= (count_ff == '0) ? '0 : cell_ff[last_idx[IDX_W-1:0]];
         min_value   <= (count_ff == '0) ? '0 : cell_ff[0];
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("count above capacity");
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      ctrl.exec && drop_in |=> full)
      else $error("drop without full store");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !ctrl.exec |=> $stable(count_ff))
      else $error("count moved outside execute");
   a_min_order: assert property (@(posedge clock) disable iff (reset)
      ctrl.report && count_ff != '0 |->
      $signed(cell_ff[0]) <= $signed(cell_ff[last_idx[IDX_W-1:0]]))
      else $error("min above max");
`endif

endmodule

// ===== rtl/double_ended_priority_queue_top.sv =====
// Top level of the double-ended priority queue.
//
//  channel | dir | tdata (low bit up)                           | tuser
//  req     | in  | value[31:0]                                  | kind[1:0]
//  rsp     | out | max, min, is_empty, entry_count, dropped, 0s | -
//
// Each word passes through accept, execute on the sorted cell row, and report, in that order.
// The cell row shifts all cells at once, so the time does not depend on count.
// Reset empties the queue; cell contents are left as they are.
// A waiting result does not block acceptance of the next word; the report
// step waits until the result register is free.
module double_ended_priority_queue_top
   import depq_pkg::*;
#(
   parameter int CAPACITY = DefCapacity,
   parameter int CNT_W    = $clog2(CAPACITY + 1),
   parameter int RSP_W    = ((2 * ValueW + CNT_W + 2 + 7) / 8) * 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [ValueW-1:0] req_tdata,   // value
   input  logic [KindW-1:0]  req_tuser,   // kind
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata    // max, min, is_empty, entry_count, dropped
);

   ctrl_type          ctrl;
   logic [ValueW-1:0] max_value, min_value;
   logic              is_empty, dropped;
   logic [CNT_W-1:0]  entry_count;

   depq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctrl       (ctrl)
   );

   depq_dpath #(.CAPACITY(CAPACITY), .CNT_W(CNT_W)) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .req_kind    (req_tuser),
      .req_value   (req_tdata),
      .max_value   (max_value),
      .min_value   (min_value),
      .is_empty    (is_empty),
      .entry_count (entry_count),
      .dropped     (dropped)
   );

   assign rsp_tdata = RSP_W'({dropped, entry_count, is_empty, min_value, max_value});

endmodule
